[hdl/id_tsr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_tsr_pkg
// Shared types and constants for the id table with swap-on-remove.
// ----------------------------------------------------------------------------
package id_tsr_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int KEY_W   = 16;
    localparam int VAL_W   = 8;
    localparam int ENTRY_W = KEY_W + VAL_W;
    localparam int POS_W   = 10;
    localparam int FILL_W  = 11;

    // command kinds
    localparam logic [1:0] KIND_ASSIGN   = 2'd0;
    localparam logic [1:0] KIND_UNASSIGN = 2'd1;
    localparam logic [1:0] KIND_LOOKUP   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // one finished result, handed from the sequencer to the output register
    typedef struct packed {
        status_t              status;
        logic [POS_W-1:0]     position;
        logic [VAL_W-1:0]     found_value;
        logic [FILL_W-1:0]    fill_count;
    } res_t;

endpackage

[hdl/id_tsr_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_tsr_store
// Entry memory: {id, value} words, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module id_tsr_store #(
    parameter int DEPTH  = id_tsr_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [ADDR_W-1:0]              wr_addr,
    input  logic [id_tsr_pkg::ENTRY_W-1:0] wr_data,
    input  logic                           rd_en,
    input  logic [ADDR_W-1:0]              rd_addr,
    output logic [id_tsr_pkg::ENTRY_W-1:0] rd_data
);
    import id_tsr_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/id_tsr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_tsr_ctrl
// Command sequencer with the shared id comparator: fast-path probe, linear
// scan, swap of the last entry into a removed slot, fill count.
// ----------------------------------------------------------------------------
module id_tsr_ctrl #(
    parameter int DEPTH  = id_tsr_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // command side
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  logic [1:0]                     cmd_kind,
    input  logic [id_tsr_pkg::KEY_W-1:0]   cmd_id,
    input  logic [id_tsr_pkg::VAL_W-1:0]   cmd_value,
    // result side
    output logic                           res_valid,
    input  logic                           res_ready,
    output id_tsr_pkg::res_t               res,
    // memory port
    output logic                           wr_en,
    output logic [ADDR_W-1:0]              wr_addr,
    output logic [id_tsr_pkg::ENTRY_W-1:0] wr_data,
    output logic                           rd_en,
    output logic [ADDR_W-1:0]              rd_addr,
    input  logic [id_tsr_pkg::ENTRY_W-1:0] rd_data
);
    import id_tsr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_FAST_CHK = 6'b000010,
        S_SCAN     = 6'b000100,
        S_LAST_RD  = 6'b001000,
        S_LAST_WR  = 6'b010000,
        S_RESP     = 6'b100000
    } state_t;

    state_t              state_reg,     state_next;
    logic [1:0]          kind_reg,      kind_next;
    logic [KEY_W-1:0]    key_reg,       key_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [CNT_W-1:0]    ptr_reg,       ptr_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [ADDR_W-1:0]   chk_idx_reg,   chk_idx_next;
    logic [ADDR_W-1:0]   idx_reg,       idx_next;
    logic [VAL_W-1:0]    val_reg,       val_next;
    status_t             status_reg,    status_next;

    logic                hit;
    logic                fast_ok;
    logic [31:0]         id_ext;
    logic [31:0]         idx_ext;
    logic [31:0]         cnt_ext;
    logic [CNT_W-1:0]    last;

    assign id_ext  = 32'(cmd_id);
    assign fast_ok = id_ext < 32'(count_reg);
    assign last    = count_reg - CNT_W'(1);
    // shared comparator: checks the word read in the previous cycle
    assign hit     = chk_valid_reg && (rd_data[ENTRY_W-1:VAL_W] == key_reg);

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg[ADDR_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = count_reg[ADDR_W-1:0];
        wr_data        = {cmd_id, cmd_value};

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    kind_next = cmd_kind;
                    key_next  = cmd_id;
                    idx_next  = '0;
                    val_next  = '0;
                    case (cmd_kind)
                        KIND_ASSIGN: begin
                            if (count_reg == CNT_W'(DEPTH)) begin
                                status_next = ST_FULL;
                            end else begin
                                wr_en       = 1'b1;
                                idx_next    = count_reg[ADDR_W-1:0];
                                count_next  = count_reg + CNT_W'(1);
                                status_next = ST_OK;
                            end
                            state_next = S_RESP;
                        end
                        KIND_UNASSIGN, KIND_LOOKUP: begin
                            // fast path: probe the entry at index id
                            if (fast_ok) begin
                                rd_en          = 1'b1;
                                rd_addr        = id_ext[ADDR_W-1:0];
                                chk_valid_next = 1'b1;
                                chk_idx_next   = id_ext[ADDR_W-1:0];
                            end
                            state_next = S_FAST_CHK;
                        end
                        default: begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_RESP;
                        end
                    endcase
                end
            end
            S_FAST_CHK, S_SCAN: begin
                if (hit) begin
                    idx_next    = chk_idx_reg;
                    val_next    = rd_data[VAL_W-1:0];
                    status_next = ST_OK;
                    if (kind_reg == KIND_UNASSIGN && chk_idx_reg != last[ADDR_W-1:0]) begin
                        state_next = S_LAST_RD;
                    end else begin
                        if (kind_reg == KIND_UNASSIGN) begin
                            count_next = last;
                        end
                        state_next = S_RESP;
                    end
                end else if (state_reg == S_FAST_CHK) begin
                    ptr_next   = '0;
                    state_next = S_SCAN;
                end else if (ptr_reg >= count_reg) begin
                    idx_next    = '0;
                    val_next    = '0;
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end else begin
                    // one read issued per cycle, checked the cycle after
                    rd_en          = 1'b1;
                    rd_addr        = ptr_reg[ADDR_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = ptr_reg[ADDR_W-1:0];
                    ptr_next       = ptr_reg + CNT_W'(1);
                end
            end
            S_LAST_RD: begin
                rd_en      = 1'b1;
                rd_addr    = last[ADDR_W-1:0];
                state_next = S_LAST_WR;
            end
            S_LAST_WR: begin
                // move the last entry into the freed slot
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = rd_data;
                count_next = last;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        ptr_reg     <= ptr_next;
        chk_idx_reg <= chk_idx_next;
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
    end

    assign idx_ext = 32'(idx_reg);
    assign cnt_ext = 32'(count_reg);

    // no transaction is taken while reset is held
    assign cmd_ready       = aresetn && (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_RESP);
    assign res.status      = status_reg;
    assign res.position    = idx_ext[POS_W-1:0];
    assign res.found_value = val_reg;
    assign res.fill_count  = cnt_ext[FILL_W-1:0];

endmodule

[hdl/id_table_swap_remove_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_table_swap_remove_core
// Unordered (id, value) table with fill count: assign, unassign with
// swap-on-remove, and lookup with an index fast path and a linear scan.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                           Direction
//  -------  ----------------------------------------------  ---------
//  s_       kind, entry_id, entry_value                     in
//  m_       status, position, found_value, fill_count       out
//
//  Assign writes its entry and answers. Unassign and lookup probe index id
//  first; on a miss the scan reads one entry per cycle through the single
//  memory read port, up to the fill count. An unassign of a slot other than
//  the last then moves the last entry into it. One transaction is in flight
//  at a time. The output register frees the sequencer once a result is
//  loaded, so a stalled m_ready delays only the next result. Reset clears
//  the fill count and handshake state; table memory needs no clearing pass.
//
module id_table_swap_remove_core #(
    parameter int TABLE_DEPTH = id_tsr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_kind,
    input  logic [id_tsr_pkg::KEY_W-1:0] s_entry_id,
    input  logic [id_tsr_pkg::VAL_W-1:0] s_entry_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [id_tsr_pkg::POS_W-1:0] m_position,
    output logic [id_tsr_pkg::VAL_W-1:0] m_found_value,
    output logic [id_tsr_pkg::FILL_W-1:0] m_fill_count
);
    import id_tsr_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0]  rd_data;

    logic                res_valid;
    logic                res_ready;
    res_t                res;

    // output register
    logic                m_valid_reg, m_valid_next;
    res_t                m_res_reg,   m_res_next;

    id_tsr_store #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    id_tsr_ctrl #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_valid),
        .cmd_ready (s_ready),
        .cmd_kind  (s_kind),
        .cmd_id    (s_entry_id),
        .cmd_value (s_entry_value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // load when empty or when the held result is being taken
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_res_reg.status;
    assign m_position    = m_res_reg.position;
    assign m_found_value = m_res_reg.found_value;
    assign m_fill_count  = m_res_reg.fill_count;

endmodule

[verif/id_table_swap_remove_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_table_swap_remove_core_tb
// Self-checking bench for the id table: a mirror of the table predicts the
// answer to every accepted command, and each answer that leaves the block is
// checked against it field by field. Directed commands come first, then a
// random mix kept at small fill.
// ----------------------------------------------------------------------------
module id_table_swap_remove_core_tb;
    import id_tsr_pkg::*;

    localparam int TBL_DEPTH  = TABLE_DEPTH_DEF;
    localparam int RAND_CMDS  = 558;
    localparam int IDLE_PCT   = 11;

    // kind code with no command behind it
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Mirror of the table: applies each accepted command and queues the answer.
    class table_mirror;
        logic [KEY_W-1:0] ids [TBL_DEPTH];
        logic [VAL_W-1:0] vals [TBL_DEPTH];
        int unsigned      fill;
        res_t             pending_answers[$];
        int unsigned      mismatches;

        function new();
            fill        = 0;
            mismatches  = 0;
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            $display("%0t ns: %s", $time, what);
        endtask

        // index fast path first, then lowest matching index
        function bit locate(input logic [KEY_W-1:0] key, output int unsigned where);
            where = 0;
            if (key < fill && ids[key] == key) begin
                where = key;
                return 1'b1;
            end
            for (int unsigned i = 0; i < fill; i++) begin
                if (ids[i] == key) begin
                    where = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void apply_command(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                                    input logic [VAL_W-1:0] val);
            res_t             ans;
            int unsigned      idx;
            int unsigned      last;
            logic [KEY_W-1:0] tmp_id;
            logic [VAL_W-1:0] tmp_val;
            ans.status      = ST_NOT_FOUND;
            ans.position    = '0;
            ans.found_value = '0;
            case (kind)
                KIND_ASSIGN: begin
                    if (fill >= TBL_DEPTH) begin
                        ans.status = ST_FULL;
                    end else begin
                        ids[fill]    = key;
                        vals[fill]   = val;
                        ans.status   = ST_OK;
                        ans.position = POS_W'(fill);
                        fill++;
                    end
                end
                KIND_UNASSIGN: begin
                    if (locate(key, idx)) begin
                        ans.status      = ST_OK;
                        ans.position    = POS_W'(idx);
                        ans.found_value = vals[idx];
                        last            = fill - 1;
                        if (idx != last) begin
                            tmp_id     = ids[idx];
                            tmp_val    = vals[idx];
                            ids[idx]   = ids[last];
                            vals[idx]  = vals[last];
                            ids[last]  = tmp_id;
                            vals[last] = tmp_val;
                        end
                        fill = last;
                    end
                end
                KIND_LOOKUP: begin
                    if (locate(key, idx)) begin
                        ans.status      = ST_OK;
                        ans.position    = POS_W'(idx);
                        ans.found_value = vals[idx];
                    end
                end
                default: ;
            endcase
            ans.fill_count = FILL_W'(fill);
            pending_answers.push_back(ans);
        endfunction

        task match_answer(input logic [1:0] status, input logic [POS_W-1:0] position,
                          input logic [VAL_W-1:0] found_value,
                          input logic [FILL_W-1:0] fill_count);
            res_t want;
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected answer status=%0d pos=%0d",
                                          status, position));
                return;
            end
            want = pending_answers.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", status, want.status));
            if (position !== want.position)
                report_mismatch($sformatf("position got %0d want %0d",
                                          position, want.position));
            if (found_value !== want.found_value)
                report_mismatch($sformatf("found_value got 0x%02h want 0x%02h",
                                          found_value, want.found_value));
            if (fill_count !== want.fill_count)
                report_mismatch($sformatf("fill_count got %0d want %0d",
                                          fill_count, want.fill_count));
        endtask
    endclass

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [1:0]          s_kind        = KIND_LOOKUP;
    logic [KEY_W-1:0]    s_entry_id    = '0;
    logic [VAL_W-1:0]    s_entry_value = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [1:0]          m_status;
    logic [POS_W-1:0]    m_position;
    logic [VAL_W-1:0]    m_found_value;
    logic [FILL_W-1:0]   m_fill_count;

    // set during one long stretch: no sender gaps, no receiver stalls
    bit                  steady_flow   = 1'b0;

    table_mirror mirror = new();

    id_table_swap_remove_core #(
        .TABLE_DEPTH (TBL_DEPTH)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_entry_id    (s_entry_id),
        .s_entry_value (s_entry_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_position    (m_position),
        .m_found_value (m_found_value),
        .m_fill_count  (m_fill_count)
    );

    always #10 aclk = ~aclk;

    // Receiver: holds ready low about 11 percent of the time unless in the steady stretch.
    always @(posedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Result monitor: a transaction completes at the edge where valid and ready
    // are both high; values read here are the ones present at that edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            mirror.match_answer(m_status, m_position, m_found_value, m_fill_count);
    end

    // Present one command and hold it until the block takes it. An optional gap
    // with valid low comes first, so gaps land on any phase of the block's work.
    task automatic send_command(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] val);
        if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_entry_id    <= key;
        s_entry_value <= val;
        do @(posedge aclk); while (s_ready !== 1'b1);
        mirror.apply_command(kind, key, val);
    endtask

    // Any stored id, or a random one when the table is empty.
    function automatic logic [KEY_W-1:0] stored_key();
        if (mirror.fill == 0)
            return KEY_W'($urandom);
        return mirror.ids[$urandom_range(0, mirror.fill - 1)];
    endfunction

    // Random command at small fill: mostly hits on stored ids, some misses,
    // duplicates, ids equal to their slot (fast path) and the unused kind.
    task automatic random_command();
        int unsigned      pick;
        int unsigned      assign_pct;
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
        pick       = $urandom_range(0, 99);
        assign_pct = (mirror.fill < 8) ? 70 : (mirror.fill > 60) ? 15 : 42;
        if (pick < 3)
            kind = KIND_UNUSED;
        else if (pick < 3 + assign_pct)
            kind = KIND_ASSIGN;
        else if (pick < 3 + assign_pct + (97 - assign_pct) / 2)
            kind = KIND_UNASSIGN;
        else
            kind = KIND_LOOKUP;
        pick = $urandom_range(0, 99);
        if (kind == KIND_ASSIGN) begin
            if (pick < 40)      key = KEY_W'(mirror.fill);
            else if (pick < 60) key = stored_key();
            else if (pick < 70) key = KEY_W'($urandom_range(0, 63));
            else                key = KEY_W'($urandom);
        end else begin
            if (pick < 75)      key = stored_key();
            else if (pick < 85) key = KEY_W'($urandom_range(0, mirror.fill + 2));
            else                key = KEY_W'($urandom);
        end
        send_command(kind, key, VAL_W'($urandom));
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, unused kind, field extremes, duplicates,
        // fast-path hits and misses, swap on remove, removal of the last entry.
        send_command(KIND_LOOKUP,   16'h0000, 8'h00);
        send_command(KIND_UNASSIGN, 16'hFFFF, 8'hFF);
        send_command(KIND_UNUSED,   16'hFFFF, 8'hFF);
        send_command(KIND_ASSIGN,   16'h0000, 8'h00);
        send_command(KIND_ASSIGN,   16'h0001, 8'hFF);
        send_command(KIND_ASSIGN,   16'hFFFF, 8'hA5);
        send_command(KIND_ASSIGN,   16'hFFFF, 8'h3C);   // duplicate id
        send_command(KIND_ASSIGN,   16'h0005, 8'h11);
        send_command(KIND_ASSIGN,   16'h0003, 8'h22);   // slot 3 holds another id
        send_command(KIND_LOOKUP,   16'h0000, 8'hFF);
        send_command(KIND_LOOKUP,   16'h0001, 8'h00);
        send_command(KIND_LOOKUP,   16'hFFFF, 8'h00);   // lowest duplicate wins
        send_command(KIND_LOOKUP,   16'h0003, 8'h00);   // fast path misses, scan hits
        send_command(KIND_LOOKUP,   16'h1234, 8'h00);
        send_command(KIND_UNASSIGN, 16'hFFFF, 8'h00);   // swap with last entry
        send_command(KIND_LOOKUP,   16'hFFFF, 8'h00);
        send_command(KIND_UNASSIGN, 16'h0003, 8'h00);
        send_command(KIND_UNASSIGN, 16'hFFFF, 8'h00);   // last entry, no swap
        send_command(KIND_UNASSIGN, 16'hFFFF, 8'h00);
        send_command(KIND_UNUSED,   16'h0000, 8'h5A);   // state must not move
        send_command(KIND_LOOKUP,   16'h0000, 8'h00);
        send_command(KIND_LOOKUP,   16'h0005, 8'h00);

        // Random mix at small fill, with one long stretch of no idling.
        for (int i = 0; i < RAND_CMDS; i++) begin
            steady_flow = (i >= 250 && i < 350);
            random_command();
        end
        steady_flow = 1'b0;
        s_valid <= 1'b0;

        // Drain: every answer in, then an idle stretch for stray outputs.
        while (mirror.pending_answers.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mirror.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit: far above the slowest legal run of this stimulus.
    initial begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
